FILE: hw/rtl/lscc_pkg.sv
// Shared types and constants of the level-set cell contour block.
// No dependencies; every other file imports it.
package lscc_pkg;

  localparam int GRID_SIZE  = 1024;
  localparam int FRAC_BITS  = 16;
  localparam int CELL_W     = 10;
  localparam int DIST_W     = 32;
  localparam int NCORNER    = 4;
  localparam int COORD_W    = 27;
  localparam int LEN_W      = 17;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Edge interpolation divider
  localparam int MAG_W      = DIST_W;
  localparam int DEN_W      = MAG_W + 1;
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int NUM_W      = MAG_W + QUO_BITS;
  localparam int DIV_STAGES = QUO_BITS;
  localparam int SUM_W      = DIST_W + 2;

  // Segment length
  localparam int DELTA_W     = FRAC_BITS + 1;
  localparam int SUMSQ_W     = 2 * DELTA_W;
  localparam int ROOT_W      = DELTA_W;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int SQ_REM_W    = ROOT_W + 4;
  localparam int LEN_LAT     = SQRT_STEPS + 4;

  localparam int MAX_SEG    = 4;
  localparam int SEG_CNT_W  = 3;
  localparam int SEG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_MODE = 1'b0,
    CFG_TOLERANCE   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CS_IN,
    CS_OUT,
    CS_BND
  } corner_st_t;

  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [NUM_W-1:0]    num_t;
  typedef logic [DEN_W-1:0]    den_t;
  typedef logic [QUO_BITS-1:0] quo_t;
  typedef logic [LEN_W-1:0]    len_t;

  typedef struct packed {
    logic [CELL_W-1:0]               gx;
    logic [CELL_W-1:0]               gy;
    corner_st_t [NCORNER-1:0]        st;
    logic [NCORNER-1:0]              cut;
    logic [NCORNER-1:0]              bedge;
    logic                            mixed;
    logic                            skip;
    logic                            sum_pos;
    logic                            sum_neg;
  } cls_t;

  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
  } seg_t;

  typedef struct packed {
    seg_t [MAX_SEG-1:0]   seg;
    logic [SEG_CNT_W-1:0] cnt;
    logic                 centre;
  } build_t;

endpackage

FILE: hw/rtl/lscc_if.sv
// Valid/ready channel interfaces for cell beats and segment beats.
// Depends on lscc_pkg.
interface lscc_in_if;
  import lscc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CELL_W-1:0]        cell_x;
  logic [CELL_W-1:0]        cell_y;
  logic signed [DIST_W-1:0] corner_dist0;
  logic signed [DIST_W-1:0] corner_dist1;
  logic signed [DIST_W-1:0] corner_dist2;
  logic signed [DIST_W-1:0] corner_dist3;
  logic [NCORNER-1:0]       band_flags;

  modport source (output valid, cell_x, cell_y, corner_dist0, corner_dist1,
                  corner_dist2, corner_dist3, band_flags, input ready);
  modport sink (input valid, cell_x, cell_y, corner_dist0, corner_dist1,
                corner_dist2, corner_dist3, band_flags, output ready);
endinterface

interface lscc_out_if;
  import lscc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic [LEN_W-1:0]   seg_length;
  logic               center_in;
  logic               last_segment;

  modport source (output valid, start_x, start_y, end_x, end_y, seg_length,
                  center_in, last_segment, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, seg_length,
                center_in, last_segment, output ready);
endinterface

FILE: hw/rtl/level_set_cell_contour_top.sv
// Channel       | dir | beat
// in_ch         | in  | one grid cell: position, four corner distances, band flags
// out_ch        | out | one contour segment: endpoints, length, saddle flag, last flag
// cfg_wr_en/... | in  | register write: 0 target_mode, 1 boundary_tolerance
//
// One cell enters per cycle while the output is not stalled; a cell yielding n
// segments (n up to 4) stalls the input while the output register sends them. The
// path to the first beat runs through the input, classify, divider, segment build,
// length and output registers. Synchronous reset clears valid bits and the index.
// An output stall freezes the whole pipeline; no beat is lost or repeated.
module level_set_cell_contour_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [lscc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lscc_pkg::CFG_DATA_W-1:0]    cfg_data,
  lscc_in_if.sink                            in_ch,
  lscc_out_if.source                         out_ch
);
  import lscc_pkg::*;

  logic               target_mode;
  logic [TOL_W-1:0]   boundary_tolerance;
  logic               en;

  logic               v_in;
  logic [CELL_W-1:0]  cell_x_q;
  logic [CELL_W-1:0]  cell_y_q;
  dist_t [NCORNER-1:0] dist_q;
  logic [NCORNER-1:0] flags_q;

  logic               v_cls;
  cls_t               cls;
  num_t [NCORNER-1:0] num;
  den_t [NCORNER-1:0] den;

  logic               vdiv     [DIV_STAGES];
  cls_t               cls_pipe [DIV_STAGES];
  quo_t [NCORNER-1:0] quo;

  logic               v_bld;
  build_t             bld;

  logic               vlen     [LEN_LAT];
  build_t             bld_pipe [LEN_LAT];
  len_t [MAX_SEG-1:0] len;

  logic                 ser_valid;
  logic [SEG_IDX_W-1:0] ser_idx;
  logic [SEG_CNT_W-1:0] ser_cnt;
  seg_t [MAX_SEG-1:0]   ser_seg;
  len_t [MAX_SEG-1:0]   ser_len;
  logic                 ser_centre;
  logic                 ser_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_mode        <= 1'b0;
      boundary_tolerance <= TOL_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TARGET_MODE: target_mode        <= cfg_data[0];
        CFG_TOLERANCE:   boundary_tolerance <= TOL_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign ser_last = ({1'b0, ser_idx} + SEG_CNT_W'(1)) == ser_cnt;
  // advance when the output register is empty or sends its last beat
  assign en       = !ser_valid || (out_ch.ready && ser_last);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in  <= 1'b0;
      v_cls <= 1'b0;
      v_bld <= 1'b0;
      for (int j = 0; j < DIV_STAGES; j++) vdiv[j] <= 1'b0;
      for (int j = 0; j < LEN_LAT; j++) vlen[j] <= 1'b0;
    end else if (en) begin
      v_in  <= in_ch.valid;
      v_cls <= v_in;
      vdiv[0] <= v_cls;
      for (int j = 1; j < DIV_STAGES; j++) vdiv[j] <= vdiv[j-1];
      v_bld <= vdiv[DIV_STAGES-1];
      vlen[0] <= v_bld;
      for (int j = 1; j < LEN_LAT; j++) vlen[j] <= vlen[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_x_q  <= in_ch.cell_x;
      cell_y_q  <= in_ch.cell_y;
      dist_q[0] <= in_ch.corner_dist0;
      dist_q[1] <= in_ch.corner_dist1;
      dist_q[2] <= in_ch.corner_dist2;
      dist_q[3] <= in_ch.corner_dist3;
      flags_q   <= in_ch.band_flags;
      cls_pipe[0] <= cls;
      for (int j = 1; j < DIV_STAGES; j++) cls_pipe[j] <= cls_pipe[j-1];
      bld_pipe[0] <= bld;
      for (int j = 1; j < LEN_LAT; j++) bld_pipe[j] <= bld_pipe[j-1];
    end
  end

  lscc_classify u_classify (
    .clk         (clk),
    .en          (en),
    .target_mode (target_mode),
    .tol         (boundary_tolerance),
    .cell_x      (cell_x_q),
    .cell_y      (cell_y_q),
    .corner_d    (dist_q),
    .flags       (flags_q),
    .cls         (cls),
    .num         (num),
    .den         (den)
  );

  lscc_div u_div (
    .clk (clk),
    .en  (en),
    .num (num),
    .den (den),
    .quo (quo)
  );

  lscc_seg_build u_seg_build (
    .clk (clk),
    .en  (en),
    .cls (cls_pipe[DIV_STAGES-1]),
    .quo (quo),
    .bld (bld)
  );

  lscc_sqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .seg (bld.seg),
    .len (len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_idx   <= '0;
    end else if (en) begin
      ser_valid <= vlen[LEN_LAT-1] && (bld_pipe[LEN_LAT-1].cnt != '0);
      ser_idx   <= '0;
    end else if (out_ch.ready) begin
      ser_idx <= ser_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ser_cnt    <= bld_pipe[LEN_LAT-1].cnt;
      ser_seg    <= bld_pipe[LEN_LAT-1].seg;
      ser_centre <= bld_pipe[LEN_LAT-1].centre;
      ser_len    <= len;
    end
  end

  assign out_ch.valid         = ser_valid;
  assign out_ch.start_x       = ser_seg[ser_idx].ax;
  assign out_ch.start_y       = ser_seg[ser_idx].ay;
  assign out_ch.end_x         = ser_seg[ser_idx].bx;
  assign out_ch.end_y         = ser_seg[ser_idx].by;
  assign out_ch.seg_length    = ser_len[ser_idx];
  assign out_ch.center_in     = ser_centre;
  assign out_ch.last_segment  = ser_last;

`ifndef ASSERT_OFF
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    ser_valid |-> (ser_cnt != '0) && ({1'b0, ser_idx} < ser_cnt))
    else $error("segment index beyond count");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted during output stall");

  a_next_segment: assert property (@(posedge clk) disable iff (rst)
    (ser_valid && out_ch.ready && !ser_last) |=>
      (ser_valid && ser_idx == $past(ser_idx) + 1'b1))
    else $error("segment sequence broken");
`endif

endmodule

FILE: hw/rtl/lscc_classify.sv
// Corner classification, edge activity and divider operands; one register stage.
// Depends on lscc_pkg.
module lscc_classify (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic                                      target_mode,
  input  logic [lscc_pkg::TOL_W-1:0]                tol,
  input  logic [lscc_pkg::CELL_W-1:0]               cell_x,
  input  logic [lscc_pkg::CELL_W-1:0]               cell_y,
  input  lscc_pkg::dist_t [lscc_pkg::NCORNER-1:0]   corner_d,
  input  logic [lscc_pkg::NCORNER-1:0]              flags,
  output lscc_pkg::cls_t                            cls,
  output lscc_pkg::num_t [lscc_pkg::NCORNER-1:0]    num,
  output lscc_pkg::den_t [lscc_pkg::NCORNER-1:0]    den
);
  import lscc_pkg::*;

  logic [MAG_W-1:0]       mag [NCORNER];
  cls_t                   cls_next;
  num_t [NCORNER-1:0]     num_next;
  den_t [NCORNER-1:0]     den_next;
  logic [SUM_W-1:0]       sum;
  logic                   any_in;
  logic                   any_out;
  logic                   act;

  always_comb begin
    cls_next = '0;
    num_next = '0;
    den_next = '0;
    any_in   = 1'b0;
    any_out  = 1'b0;
    act      = 1'b0;
    sum      = '0;
    cls_next.gx = (int'(cell_x) > GRID_SIZE - 1) ? CELL_W'(GRID_SIZE - 1) : cell_x;
    cls_next.gy = (int'(cell_y) > GRID_SIZE - 1) ? CELL_W'(GRID_SIZE - 1) : cell_y;
    for (int k = 0; k < NCORNER; k++) begin
      mag[k] = corner_d[k][DIST_W-1] ? MAG_W'(~corner_d[k] + 1'b1) : MAG_W'(corner_d[k]);
      sum    = sum + {{(SUM_W-DIST_W){corner_d[k][DIST_W-1]}}, corner_d[k]};
      if (mag[k] < MAG_W'(tol)) begin
        cls_next.st[k] = CS_BND;
      end else if (corner_d[k][DIST_W-1]) begin
        cls_next.st[k] = CS_OUT;
        any_out = 1'b1;
      end else begin
        cls_next.st[k] = CS_IN;
        any_in = 1'b1;
      end
    end
    for (int k = 0; k < NCORNER; k++) begin
      act = target_mode | flags[k] | flags[(k+1)%NCORNER];
      cls_next.cut[k] = act &&
        ((cls_next.st[k] == CS_IN && cls_next.st[(k+1)%NCORNER] == CS_OUT) ||
         (cls_next.st[k] == CS_OUT && cls_next.st[(k+1)%NCORNER] == CS_IN));
      cls_next.bedge[k] = act && cls_next.st[k] == CS_BND &&
                          cls_next.st[(k+1)%NCORNER] == CS_BND;
      den_next[k] = DEN_W'(mag[k]) + DEN_W'(mag[(k+1)%NCORNER]);
      num_next[k] = (NUM_W'(mag[k]) << FRAC_BITS) + NUM_W'(den_next[k] >> 1);
    end
    cls_next.mixed   = any_out;
    cls_next.skip    = any_out && !any_in;
    cls_next.sum_neg = sum[SUM_W-1];
    cls_next.sum_pos = !sum[SUM_W-1] && (sum != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls <= cls_next;
      num <= num_next;
      den <= den_next;
    end
  end

endmodule

FILE: hw/rtl/lscc_div.sv
// Four-lane pipelined restoring divider for the edge cut fractions.
// One quotient bit per stage; depends on lscc_pkg.
module lscc_div (
  input  logic                                   clk,
  input  logic                                   en,
  input  lscc_pkg::num_t [lscc_pkg::NCORNER-1:0] num,
  input  lscc_pkg::den_t [lscc_pkg::NCORNER-1:0] den,
  output lscc_pkg::quo_t [lscc_pkg::NCORNER-1:0] quo
);
  import lscc_pkg::*;

  logic [DEN_W-1:0]    rem_q [DIV_STAGES][NCORNER];
  logic [QUO_BITS-1:0] low_q [DIV_STAGES][NCORNER];
  logic [DEN_W-1:0]    den_q [DIV_STAGES][NCORNER];
  logic [QUO_BITS-1:0] quo_q [DIV_STAGES][NCORNER];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [DEN_W-1:0]    rem_i [NCORNER];
    logic [QUO_BITS-1:0] low_i [NCORNER];
    logic [DEN_W-1:0]    den_i [NCORNER];
    logic [QUO_BITS-1:0] quo_i [NCORNER];
    logic [DEN_W:0]      trial [NCORNER];
    logic                ge    [NCORNER];

    always_comb begin
      for (int l = 0; l < NCORNER; l++) begin
        if (j == 0) begin
          rem_i[l] = DEN_W'(num[l][NUM_W-1:QUO_BITS]);
          low_i[l] = num[l][QUO_BITS-1:0];
          den_i[l] = den[l];
          quo_i[l] = '0;
        end else begin
          rem_i[l] = rem_q[(j > 0) ? j-1 : 0][l];
          low_i[l] = low_q[(j > 0) ? j-1 : 0][l];
          den_i[l] = den_q[(j > 0) ? j-1 : 0][l];
          quo_i[l] = quo_q[(j > 0) ? j-1 : 0][l];
        end
        trial[l] = {rem_i[l], low_i[l][QUO_BITS-1]};
        ge[l]    = trial[l] >= {1'b0, den_i[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NCORNER; l++) begin
          rem_q[j][l] <= ge[l] ? DEN_W'(trial[l] - {1'b0, den_i[l]}) : trial[l][DEN_W-1:0];
          low_q[j][l] <= low_i[l] << 1;
          den_q[j][l] <= den_i[l];
          quo_q[j][l] <= {quo_i[l][QUO_BITS-2:0], ge[l]};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NCORNER; l++) begin
      quo[l] = quo_q[DIV_STAGES-1][l];
    end
  end

endmodule

FILE: hw/rtl/lscc_seg_build.sv
// Cut points and the ordered segment list of one cell; one register stage.
// Depends on lscc_pkg.
module lscc_seg_build (
  input  logic                                   clk,
  input  logic                                   en,
  input  lscc_pkg::cls_t                         cls,
  input  lscc_pkg::quo_t [lscc_pkg::NCORNER-1:0] quo,
  output lscc_pkg::build_t                       bld
);
  import lscc_pkg::*;

  function automatic seg_t mkseg(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                                 logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by);
    seg_t s;
    s.ax = ax;
    s.ay = ay;
    s.bx = bx;
    s.by = by;
    return s;
  endfunction

  // Append a segment unless the list is already full.
  function automatic build_t append(build_t b, seg_t s);
    build_t r;
    r = b;
    if (b.cnt < SEG_CNT_W'(MAX_SEG)) begin
      r.seg[b.cnt[SEG_IDX_W-1:0]] = s;
      r.cnt = b.cnt + 1'b1;
    end
    return r;
  endfunction

  logic [COORD_W-1:0] cx  [NCORNER];
  logic [COORD_W-1:0] cy  [NCORNER];
  logic [COORD_W-1:0] cpx [NCORNER];
  logic [COORD_W-1:0] cpy [NCORNER];
  logic [COORD_W-1:0] px  [NCORNER];
  logic [COORD_W-1:0] py  [NCORNER];
  logic [SEG_CNT_W-1:0] np;
  logic [SEG_CNT_W-1:0] nb;
  logic [SEG_IDX_W-1:0] bi0;
  logic [SEG_IDX_W-1:0] bi1;
  build_t               b;

  always_comb begin
    cx[0] = COORD_W'(cls.gx) << FRAC_BITS;
    cy[0] = COORD_W'(cls.gy) << FRAC_BITS;
    cx[1] = (COORD_W'(cls.gx) + COORD_W'(1)) << FRAC_BITS;
    cy[1] = cy[0];
    cx[2] = cx[1];
    cy[2] = (COORD_W'(cls.gy) + COORD_W'(1)) << FRAC_BITS;
    cx[3] = cx[0];
    cy[3] = cy[2];

    cpx[0] = cx[0] + COORD_W'(quo[0]);  cpy[0] = cy[0];
    cpx[1] = cx[1];                      cpy[1] = cy[1] + COORD_W'(quo[1]);
    cpx[2] = cx[2] - COORD_W'(quo[2]);  cpy[2] = cy[2];
    cpx[3] = cx[3];                      cpy[3] = cy[3] - COORD_W'(quo[3]);

    // Pack cut points in edge order
    np = '0;
    for (int k = 0; k < NCORNER; k++) begin
      px[k] = '0;
      py[k] = '0;
    end
    for (int k = 0; k < NCORNER; k++) begin
      if (cls.cut[k]) begin
        px[np[SEG_IDX_W-1:0]] = cpx[k];
        py[np[SEG_IDX_W-1:0]] = cpy[k];
        np = np + 1'b1;
      end
    end

    nb  = '0;
    bi0 = '0;
    bi1 = '0;
    for (int k = 0; k < NCORNER; k++) begin
      if (cls.st[k] == CS_BND) begin
        if (nb == '0) bi0 = SEG_IDX_W'(k);
        else if (nb == SEG_CNT_W'(1)) bi1 = SEG_IDX_W'(k);
        nb = nb + 1'b1;
      end
    end

    b = '0;
    if (!cls.skip) begin
      for (int k = 0; k < NCORNER; k++) begin
        if (cls.bedge[k]) begin
          b = append(b, mkseg(cx[k], cy[k], cx[(k+1)%NCORNER], cy[(k+1)%NCORNER]));
        end
      end
      case (np)
        3'd1: begin
          for (int k = 0; k < NCORNER; k++) begin
            if (cls.st[k] == CS_BND && (cls.st[(k+1)%NCORNER] == CS_OUT ||
                                        cls.st[(k+3)%NCORNER] == CS_OUT)) begin
              b = append(b, mkseg(px[0], py[0], cx[k], cy[k]));
            end
          end
        end
        3'd2: begin
          b = append(b, mkseg(px[0], py[0], px[1], py[1]));
        end
        3'd4: begin
          b.centre = cls.sum_pos;
          if ((cls.st[0] == CS_IN && cls.sum_pos) || (cls.st[0] == CS_OUT && cls.sum_neg)) begin
            b = append(b, mkseg(px[0], py[0], px[1], py[1]));
            b = append(b, mkseg(px[2], py[2], px[3], py[3]));
          end else begin
            b = append(b, mkseg(px[0], py[0], px[3], py[3]));
            b = append(b, mkseg(px[1], py[1], px[2], py[2]));
          end
        end
        3'd0: begin
          // diagonal between the first two boundary corners
          if (cls.mixed && nb >= SEG_CNT_W'(2)) begin
            b = append(b, mkseg(cx[bi0], cy[bi0], cx[bi1], cy[bi1]));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bld <= b;
    end
  end

endmodule

FILE: hw/rtl/lscc_sqrt.sv
// Four-lane segment length: deltas, squares, sum, digit-by-digit root, rounding.
// LEN_LAT register stages; depends on lscc_pkg.
module lscc_sqrt (
  input  logic                                   clk,
  input  logic                                   en,
  input  lscc_pkg::seg_t [lscc_pkg::MAX_SEG-1:0] seg,
  output lscc_pkg::len_t [lscc_pkg::MAX_SEG-1:0] len
);
  import lscc_pkg::*;

  logic [DELTA_W-1:0]  dx    [MAX_SEG];
  logic [DELTA_W-1:0]  dy    [MAX_SEG];
  logic [SUMSQ_W-1:0]  sqx   [MAX_SEG];
  logic [SUMSQ_W-1:0]  sqy   [MAX_SEG];
  logic [SUMSQ_W-1:0]  sumsq [MAX_SEG];
  logic [SQ_REM_W-1:0] rem_q  [SQRT_STEPS][MAX_SEG];
  logic [ROOT_W-1:0]   root_q [SQRT_STEPS][MAX_SEG];
  logic [SUMSQ_W-1:0]  s_q    [SQRT_STEPS][MAX_SEG];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < MAX_SEG; l++) begin
        dx[l]    <= DELTA_W'((seg[l].ax > seg[l].bx) ? seg[l].ax - seg[l].bx
                                                     : seg[l].bx - seg[l].ax);
        dy[l]    <= DELTA_W'((seg[l].ay > seg[l].by) ? seg[l].ay - seg[l].by
                                                     : seg[l].by - seg[l].ay);
        sqx[l]   <= SUMSQ_W'(dx[l]) * SUMSQ_W'(dx[l]);
        sqy[l]   <= SUMSQ_W'(dy[l]) * SUMSQ_W'(dy[l]);
        sumsq[l] <= sqx[l] + sqy[l];
      end
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic [SQ_REM_W-1:0] rem_i  [MAX_SEG];
    logic [ROOT_W-1:0]   root_i [MAX_SEG];
    logic [SUMSQ_W-1:0]  s_i    [MAX_SEG];
    logic [SQ_REM_W-1:0] rem_t  [MAX_SEG];
    logic [SQ_REM_W-1:0] trial  [MAX_SEG];
    logic                ge     [MAX_SEG];

    always_comb begin
      for (int l = 0; l < MAX_SEG; l++) begin
        if (j == 0) begin
          rem_i[l]  = '0;
          root_i[l] = '0;
          s_i[l]    = sumsq[l];
        end else begin
          rem_i[l]  = rem_q[(j > 0) ? j-1 : 0][l];
          root_i[l] = root_q[(j > 0) ? j-1 : 0][l];
          s_i[l]    = s_q[(j > 0) ? j-1 : 0][l];
        end
        rem_t[l] = {rem_i[l][SQ_REM_W-3:0], s_i[l][SUMSQ_W-1 -: 2]};
        trial[l] = SQ_REM_W'({root_i[l], 2'b01});
        ge[l]    = rem_t[l] >= trial[l];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < MAX_SEG; l++) begin
          rem_q[j][l]  <= ge[l] ? rem_t[l] - trial[l] : rem_t[l];
          root_q[j][l] <= {root_i[l][ROOT_W-2:0], ge[l]};
          s_q[j][l]    <= s_i[l] << 2;
        end
      end
    end
  end

  // round to nearest: bump when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < MAX_SEG; l++) begin
        len[l] <= (rem_q[SQRT_STEPS-1][l] > SQ_REM_W'(root_q[SQRT_STEPS-1][l]))
                  ? LEN_W'(root_q[SQRT_STEPS-1][l] + 1'b1)
                  : LEN_W'(root_q[SQRT_STEPS-1][l]);
      end
    end
  end

endmodule

FILE: verif/tb_level_set_cell_contour_top.sv
// Self-checking testbench for level_set_cell_contour_top: random and directed cells,
// predicted contour segments compared beat by beat. Depends on lscc_pkg and the
// lscc_in_if / lscc_out_if channel interfaces.
module tb_level_set_cell_contour_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lscc_pkg::*;

  localparam int SETTLE_CYCLES = 2 + DIV_STAGES + 1 + LEN_LAT + 20;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    logic [CELL_W-1:0]  cx;
    logic [CELL_W-1:0]  cy;
    logic [DIST_W-1:0]  cdist [NCORNER];
    logic [NCORNER-1:0] flags;
  } cell_t;

  typedef struct {
    logic [COORD_W-1:0] sx, sy, ex, ey;
    logic [LEN_W-1:0]   len;
    logic               centre;
    logic               last;
  } segment_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TARGET_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lscc_in_if  in_ch ();
  lscc_out_if out_ch ();

  level_set_cell_contour_top u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  cell_t    pending_cells [$];
  segment_t expected_segs [$];
  bit       mode_q = 0;
  int unsigned tol_q = 1;
  int       mismatches = 0;
  bit       hold_sender = 0;
  longint   cycles = 0;

  function automatic longint unsigned round_sqrt(longint unsigned s);
    longint unsigned r = 0, b = 64'd1 << 62, x = s;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic void add_segment(ref segment_t segs[$], input longint unsigned ax,
                                      input longint unsigned ay, input longint unsigned bx,
                                      input longint unsigned by, input bit centre);
    segment_t s;
    longint unsigned dx, dy;
    if (segs.size() >= MAX_SEG) return;
    ax &= 64'h7FFFFFF; ay &= 64'h7FFFFFF; bx &= 64'h7FFFFFF; by &= 64'h7FFFFFF;
    dx = ax > bx ? ax - bx : bx - ax;
    dy = ay > by ? ay - by : by - ay;
    s.sx = COORD_W'(ax); s.sy = COORD_W'(ay); s.ex = COORD_W'(bx); s.ey = COORD_W'(by);
    s.len = LEN_W'(round_sqrt(dx * dx + dy * dy));
    s.centre = centre;
    s.last = 0;
    segs.insert(segs.size(), s);
  endfunction

  // Work out the contour segments of one cell under the current register values.
  function automatic void predict_contour(cell_t c);
    longint d [4];
    longint unsigned mag [4], cx [4], cy [4], px [4], py [4];
    corner_st_t st [4];
    int nin = 0, nout = 0, ncut = 0, n, nb = 0;
    int b [2];
    longint unsigned den, f, gx, gy;
    longint sum;
    bit act, c_in;
    segment_t segs [$];
    for (int k = 0; k < 4; k++) begin
      d[k] = longint'($signed(c.cdist[k]));
      mag[k] = d[k] < 0 ? -d[k] : d[k];
      if (mag[k] < tol_q) st[k] = CS_BND;
      else if (d[k] < 0) begin st[k] = CS_OUT; nout++; end
      else begin st[k] = CS_IN; nin++; end
    end
    if (nout != 0 && nin == 0) return;
    gx = c.cx; gy = c.cy;
    cx[0] = gx << FRAC_BITS;       cy[0] = gy << FRAC_BITS;
    cx[1] = (gx + 1) << FRAC_BITS; cy[1] = cy[0];
    cx[2] = cx[1];                 cy[2] = (gy + 1) << FRAC_BITS;
    cx[3] = cx[0];                 cy[3] = cy[2];
    for (int k = 0; k < 4; k++) begin
      n = (k + 1) & 3;
      act = mode_q || c.flags[k] || c.flags[n];
      if (!act) continue;
      if ((st[k] == CS_IN && st[n] == CS_OUT) || (st[k] == CS_OUT && st[n] == CS_IN)) begin
        den = mag[k] + mag[n];
        f = ((mag[k] << FRAC_BITS) + den / 2) / den;
        px[ncut] = cx[k]; py[ncut] = cy[k];
        case (k)
          0: px[ncut] += f;
          1: py[ncut] += f;
          2: px[ncut] -= f;
          default: py[ncut] -= f;
        endcase
        ncut++;
      end else if (st[k] == CS_BND && st[n] == CS_BND) begin
        add_segment(segs, cx[k], cy[k], cx[n], cy[n], 0);
      end
    end
    if (ncut == 2) begin
      add_segment(segs, px[0], py[0], px[1], py[1], 0);
    end else if (ncut == 1) begin
      for (int k = 0; k < 4; k++)
        if (st[k] == CS_BND && (st[(k+1)&3] == CS_OUT || st[(k+3)&3] == CS_OUT))
          add_segment(segs, px[0], py[0], cx[k], cy[k], 0);
    end else if (ncut == 4) begin
      sum = d[0] + d[1] + d[2] + d[3];
      c_in = sum > 0;
      if ((st[0] == CS_IN && sum > 0) || (st[0] == CS_OUT && sum < 0)) begin
        add_segment(segs, px[0], py[0], px[1], py[1], c_in);
        add_segment(segs, px[2], py[2], px[3], py[3], c_in);
      end else begin
        add_segment(segs, px[0], py[0], px[3], py[3], c_in);
        add_segment(segs, px[1], py[1], px[2], py[2], c_in);
      end
    end else if (ncut == 0 && nout != 0) begin
      for (int k = 0; k < 4; k++)
        if (st[k] == CS_BND && nb < 2) begin b[nb] = k; nb++; end
      if (nb == 2) add_segment(segs, cx[b[0]], cy[b[0]], cx[b[1]], cy[b[1]], 0);
    end
    if (segs.size() > 0) segs[segs.size()-1].last = 1;
    foreach (segs[i]) expected_segs.insert(expected_segs.size(), segs[i]);
  endfunction

  // Distance of a given class: 0 inside, 1 outside, 2 boundary (inside at zero tolerance), 3 any value.
  function automatic logic [DIST_W-1:0] pick_dist(int cls);
    longint m;
    case ($urandom_range(0, 2))
      0: m = $urandom_range(0, 32'h3_0000);
      1: m = $urandom_range(0, 32'h0100_0000);
      default: m = $urandom_range(0, 32'h7FFF_0000);
    endcase
    if (cls == 2 && tol_q == 0) cls = 0;
    case (cls)
      0: return DIST_W'(longint'(tol_q) + m);
      1: return DIST_W'(-(longint'(tol_q) + m));
      2: return DIST_W'(longint'($urandom_range(0, 2 * (tol_q - 1))) - (tol_q - 1));
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t make_cell(int c0, int c1, int c2, int c3, logic [3:0] flags);
    cell_t c;
    c.cx = CELL_W'($urandom_range(0, 1023));
    c.cy = CELL_W'($urandom_range(0, 1023));
    c.cdist[0] = pick_dist(c0); c.cdist[1] = pick_dist(c1);
    c.cdist[2] = pick_dist(c2); c.cdist[3] = pick_dist(c3);
    c.flags = flags;
    return c;
  endfunction

  function automatic cell_t random_cell();
    logic [3:0] fl = $urandom_range(0, 1) ? 4'hF : 4'($urandom);
    if ($urandom_range(0, 4) == 0) return make_cell(3, 3, 3, 3, fl);
    return make_cell($urandom_range(0, 2), $urandom_range(0, 2),
                     $urandom_range(0, 2), $urandom_range(0, 2), fl);
  endfunction

  function automatic void add_cell(cell_t c);
    pending_cells.insert(pending_cells.size(), c);
  endfunction

  // Sender: bursts of beats separated by random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
      in_ch.cell_x <= '0; in_ch.cell_y <= '0; in_ch.band_flags <= '0;
      in_ch.corner_dist0 <= '0; in_ch.corner_dist1 <= '0;
      in_ch.corner_dist2 <= '0; in_ch.corner_dist3 <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cell_t acc;
        acc.cx = in_ch.cell_x; acc.cy = in_ch.cell_y; acc.flags = in_ch.band_flags;
        acc.cdist[0] = in_ch.corner_dist0; acc.cdist[1] = in_ch.corner_dist1;
        acc.cdist[2] = in_ch.corner_dist2; acc.cdist[3] = in_ch.corner_dist3;
        predict_contour(acc);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 0;
        end else if (pending_cells.size() > 0 && !hold_sender) begin
          cell_t c;
          c = pending_cells.pop_front();
          in_ch.valid <= 1;
          in_ch.cell_x <= c.cx; in_ch.cell_y <= c.cy; in_ch.band_flags <= c.flags;
          in_ch.corner_dist0 <= c.cdist[0]; in_ch.corner_dist1 <= c.cdist[1];
          in_ch.corner_dist2 <= c.cdist[2]; in_ch.corner_dist3 <= c.cdist[3];
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // Receiver: stall pattern, check every beat against the oldest prediction.
  int stall_phase = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      stall_phase = (stall_phase + 1) % 48;
      out_ch.ready <= stall_phase < 16 ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_segs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected segment beat at cycle %0d", cycles);
        end else begin
          segment_t e;
          e = expected_segs.pop_front();
          if (e.sx !== out_ch.start_x || e.sy !== out_ch.start_y || e.ex !== out_ch.end_x ||
              e.ey !== out_ch.end_y || e.len !== out_ch.seg_length ||
              e.centre !== out_ch.center_in || e.last !== out_ch.last_segment) begin
            mismatches++;
            if (mismatches <= 10)
              $display("segment mismatch: exp %h %h %h %h len %h c%b l%b got %h %h %h %h len %h c%b l%b",
                       e.sx, e.sy, e.ex, e.ey, e.len, e.centre, e.last,
                       out_ch.start_x, out_ch.start_y, out_ch.end_x, out_ch.end_y,
                       out_ch.seg_length, out_ch.center_in, out_ch.last_segment);
          end
        end
      end
    end
  end

  task automatic drain();
    wait (pending_cells.size() == 0 && !in_ch.valid);
    wait (expected_segs.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    if (idx == CFG_TARGET_MODE) mode_q = val[0];
    else tol_q = 32'(val);
  endtask

  initial begin
    cell_t c;
    bit modes [5] = '{0, 1, 0, 1, 0};
    int unsigned tols [5] = '{1, 0, 65535, 300, 4096};
    repeat (12) @(posedge clk);
    rst <= 0;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_TARGET_MODE, CFG_DATA_W'(modes[ph]));
        write_reg(CFG_TOLERANCE, CFG_DATA_W'(tols[ph]));
      end
      if (ph == 0) begin
        // corner extremes and every contour case
        c = make_cell(0, 1, 1, 1, 4'hF); c.cx = '0; c.cy = '0;
        c.cdist = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        add_cell(c);
        c = make_cell(1, 0, 0, 0, 4'hF); c.cx = CELL_W'(1023); c.cy = CELL_W'(1023);
        c.cdist = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF};
        add_cell(c);
        add_cell(make_cell(0, 0, 0, 0, 4'hF));
        add_cell(make_cell(1, 1, 1, 1, 4'hF));
        add_cell(make_cell(1, 1, 2, 2, 4'hF));
        add_cell(make_cell(2, 2, 0, 0, 4'hF));
        add_cell(make_cell(0, 0, 1, 1, 4'h0));
        add_cell(make_cell(0, 0, 1, 1, 4'h1));
        add_cell(make_cell(0, 1, 2, 2, 4'hF));
        add_cell(make_cell(2, 0, 2, 1, 4'hF));
        add_cell(make_cell(2, 2, 2, 1, 4'hF));
        add_cell(make_cell(0, 1, 0, 1, 4'hF));
        add_cell(make_cell(1, 0, 1, 0, 4'hF));
        add_cell(make_cell(0, 1, 0, 1, 4'h3));
        c = make_cell(0, 1, 0, 1, 4'hF);
        c.cdist = '{32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000, 32'hFFFF_8000};
        add_cell(c);
        c.cdist = '{32'h0001_0000, 32'hFFFF_8000, 32'h0001_0000, 32'hFFFE_0000};
        add_cell(c);
        add_cell(make_cell(2, 2, 2, 2, 4'hF));
        add_cell(make_cell(3, 3, 3, 3, 4'h5));
        drain();
      end
      for (int i = 0; i < 36; i++) begin
        add_cell(random_cell());
        if (ph == 2 && i == 18) begin
          // hold the sender until every predicted segment has come out
          wait (pending_cells.size() == 0 && !in_ch.valid);
          hold_sender = 1;
          wait (expected_segs.size() == 0);
          hold_sender = 0;
        end
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
